### hw/rtl/kmau_pkg.sv
// ----------------------------------------------------------------------------
// kmau_pkg: shared types and constants for the 2-D k-means unit
// Command codes, controller states and controller/datapath command structs.
// ----------------------------------------------------------------------------
package kmau_pkg;

    localparam int unsigned CLUSTER_SLOTS_DEF = 8;
    localparam int unsigned COORD_BITS_DEF    = 16;
    localparam int unsigned COUNT_BITS_DEF    = 20;
    localparam int unsigned CMD_BITS          = 2;
    localparam int unsigned SLOT_BITS         = 3;
    localparam int unsigned IO_COORD_BITS     = 16;
    localparam int unsigned K_BITS            = 4;
    localparam logic [K_BITS-1:0] K_RESET     = 4'd8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ASSIGN = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_DIST,
        ST_CMP,
        ST_ASN_OUT,
        ST_UPD_START,
        ST_UPD_DIV,
        ST_UPD_OUT,
        ST_UPD_CLR
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input item
        logic load;      // write centroid slot
        logic clr_acc;   // clear accumulator row r_clr and advance the sweep
        logic clr_cent;  // clear centroid row r_clr (reset sweep only)
        logic sq_calc;   // compute squared differences for current index
        logic cmp;       // compare and advance
        logic asn_acc;   // accumulate point and make assign result
        logic div_start; // start dividers for current index
        logic upd_out;   // store new centroid, make update result
        logic idx_rst;   // walk index to zero
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       walk_end;   // index is last active cluster
        logic       div_done;
        logic       clr_end;    // clearing sweep on last row
    } t_dp_sts;

endpackage

### hw/rtl/kmau_divider.sv
// ----------------------------------------------------------------------------
// kmau_divider: restoring divider, one quotient bit per cycle
// Computes num / den truncated, keeping the low QBITS of the quotient.
// ----------------------------------------------------------------------------
module kmau_divider #(
    parameter int unsigned NBITS = 36,
    parameter int unsigned DBITS = 20,
    parameter int unsigned QBITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NBITS-1:0] i_num,
    input  logic [DBITS-1:0] i_den,
    output logic             o_done,
    output logic [QBITS-1:0] o_quot
);
    localparam int unsigned CBITS = $clog2(NBITS + 1);

    logic             r_busy;
    logic [CBITS-1:0] r_cnt;
    logic [NBITS-1:0] r_num;
    logic [DBITS-1:0] r_den;
    logic [DBITS:0]   r_rem;
    logic [QBITS-1:0] r_quot;
    logic [DBITS:0]   w_sh;
    logic [DBITS:0]   w_diff;
    logic             w_ge;

    // shift next numerator bit into the partial remainder
    assign w_sh   = {r_rem[DBITS-1:0], r_num[NBITS-1]};
    assign w_ge   = w_sh >= {1'b0, r_den};
    assign w_diff = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CBITS'(NBITS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CBITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NBITS-2:0], 1'b0};
            r_rem  <= w_ge ? w_diff : w_sh;
            r_quot <= {r_quot[QBITS-2:0], w_ge};
        end
    end

    assign o_done = !r_busy && !i_start;
    assign o_quot = r_quot;
endmodule

### hw/rtl/kmau_datapath.sv
// ----------------------------------------------------------------------------
// kmau_datapath: centroid and accumulator tables, distance unit, dividers
// Each distance is a multiply step, then a compare step; one output register.
// ----------------------------------------------------------------------------
module kmau_datapath #(
    parameter int unsigned CLUSTER_SLOTS = kmau_pkg::CLUSTER_SLOTS_DEF,
    parameter int unsigned COORD_BITS    = kmau_pkg::COORD_BITS_DEF,
    parameter int unsigned COUNT_BITS    = kmau_pkg::COUNT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kmau_pkg::t_dp_cmd                     i_cmd,
    input  logic [kmau_pkg::K_BITS-1:0]           i_k,
    input  logic [kmau_pkg::IO_COORD_BITS-1:0]    i_x,
    input  logic [kmau_pkg::IO_COORD_BITS-1:0]    i_y,
    input  logic [kmau_pkg::SLOT_BITS-1:0]        i_slot,
    output kmau_pkg::t_dp_sts                     o_sts,
    output logic [kmau_pkg::SLOT_BITS-1:0]        o_idx,
    output logic [kmau_pkg::IO_COORD_BITS-1:0]    o_cx,
    output logic [kmau_pkg::IO_COORD_BITS-1:0]    o_cy,
    output logic                                  o_changed,
    output logic                                  o_last
);
    localparam int unsigned IW     = (CLUSTER_SLOTS > 1) ? $clog2(CLUSTER_SLOTS) : 1;
    localparam int unsigned SUMB   = COORD_BITS + COUNT_BITS;
    localparam int unsigned DISTB  = 2 * COORD_BITS + 1;
    localparam int unsigned SLOTS  = (CLUSTER_SLOTS < 8) ? CLUSTER_SLOTS : 8;
    localparam int unsigned IOB    = kmau_pkg::IO_COORD_BITS;
    localparam int unsigned SB     = kmau_pkg::SLOT_BITS;
    localparam int unsigned WB     = (IW > SB) ? IW : SB;

    logic [COORD_BITS-1:0] r_cx [CLUSTER_SLOTS];
    logic [COORD_BITS-1:0] r_cy [CLUSTER_SLOTS];
    logic [SUMB-1:0]       r_sx [CLUSTER_SLOTS];
    logic [SUMB-1:0]       r_sy [CLUSTER_SLOTS];
    logic [COUNT_BITS-1:0] r_cnt [CLUSTER_SLOTS];

    logic [COORD_BITS-1:0] r_px, r_py;
    logic [SB-1:0]         r_slot;
    logic [WB-1:0]         r_wi;     // walk index
    logic [IW-1:0]         r_clr;    // clearing sweep index
    logic [WB-1:0]         r_best;
    logic [DISTB-1:0]      r_bdist;
    logic [2*COORD_BITS-1:0] r_dx2, r_dy2;
    logic [SB-1:0]         w_lim;    // last active index
    logic                  w_div_dx, w_div_dy;
    logic [COORD_BITS-1:0] w_qx, w_qy;
    logic [COORD_BITS-1:0] w_cxi, w_cyi, w_dx, w_dy;
    logic [DISTB-1:0]      w_dist;
    logic [IW-1:0]         w_wi, w_bi;
    logic [COORD_BITS-1:0] w_nx, w_ny;

    assign w_wi = IW'(r_wi);
    assign w_bi = IW'(r_best);

    // effective k: 0 acts as 1, capped at addressable slots
    always_comb begin
        if (i_k == '0) begin
            w_lim = '0;
        end else if (i_k > kmau_pkg::K_BITS'(SLOTS)) begin
            w_lim = SB'(SLOTS - 1);
        end else begin
            w_lim = SB'(i_k - 1'b1);
        end
    end

    assign w_cxi = r_cx[w_wi];
    assign w_cyi = r_cy[w_wi];
    assign w_dx  = (r_px > w_cxi) ? r_px - w_cxi : w_cxi - r_px;
    assign w_dy  = (r_py > w_cyi) ? r_py - w_cyi : w_cyi - r_py;
    assign w_dist = {1'b0, r_dx2} + {1'b0, r_dy2};

    assign o_sts.walk_end = (SB'(r_wi) == w_lim);
    assign o_sts.div_done = w_div_dx && w_div_dy;
    assign o_sts.clr_end  = (r_clr == IW'(CLUSTER_SLOTS - 1));

    // input capture, distance squares, walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px   <= COORD_BITS'(i_x);
            r_py   <= COORD_BITS'(i_y);
            r_slot <= i_slot;
        end
        if (i_cmd.sq_calc) begin
            r_dx2 <= w_dx * w_dx;
            r_dy2 <= w_dy * w_dy;
        end
        if (i_cmd.idx_rst) begin
            r_wi <= '0;
        end else if (i_cmd.cmp || i_cmd.upd_out) begin
            r_wi <= r_wi + 1'b1;
        end
        if (i_cmd.cmp) begin
            if (r_wi == '0 || w_dist < r_bdist) begin
                r_best  <= r_wi;
                r_bdist <= w_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_acc) begin
            r_clr <= o_sts.clr_end ? '0 : r_clr + 1'b1;
        end
    end

    kmau_divider #(.NBITS(SUMB), .DBITS(COUNT_BITS), .QBITS(COORD_BITS)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_sx[w_wi]), .i_den(r_cnt[w_wi]), .o_done(w_div_dx), .o_quot(w_qx)
    );
    kmau_divider #(.NBITS(SUMB), .DBITS(COUNT_BITS), .QBITS(COORD_BITS)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_sy[w_wi]), .i_den(r_cnt[w_wi]), .o_done(w_div_dy), .o_quot(w_qy)
    );

    assign w_nx = (r_cnt[w_wi] != '0) ? w_qx : w_cxi;
    assign w_ny = (r_cnt[w_wi] != '0) ? w_qy : w_cyi;

    // tables and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_acc) begin
            r_sx[r_clr]  <= '0;
            r_sy[r_clr]  <= '0;
            r_cnt[r_clr] <= '0;
        end
        if (i_cmd.clr_cent) begin
            r_cx[r_clr] <= '0;
            r_cy[r_clr] <= '0;
        end
        if (i_cmd.load && ({1'b0, r_slot} < (SB+1)'(SLOTS))) begin
            r_cx[IW'(r_slot)] <= r_px;
            r_cy[IW'(r_slot)] <= r_py;
        end
        if (i_cmd.asn_acc) begin
            o_idx     <= SB'(r_best);
            o_cx      <= IOB'(r_cx[w_bi]);
            o_cy      <= IOB'(r_cy[w_bi]);
            o_changed <= (SB'(r_best) != r_slot);
            o_last    <= 1'b1;
            if (r_cnt[w_bi] != {COUNT_BITS{1'b1}}) begin
                r_cnt[w_bi] <= r_cnt[w_bi] + 1'b1;
                r_sx[w_bi]  <= r_sx[w_bi] + SUMB'(r_px);
                r_sy[w_bi]  <= r_sy[w_bi] + SUMB'(r_py);
            end
        end
        if (i_cmd.upd_out) begin
            o_idx       <= SB'(r_wi);
            o_cx        <= IOB'(w_nx);
            o_cy        <= IOB'(w_ny);
            o_changed   <= (w_nx != w_cxi) || (w_ny != w_cyi);
            o_last      <= o_sts.walk_end;
            r_cx[w_wi]  <= w_nx;
            r_cy[w_wi]  <= w_ny;
        end
    end

    // assign result must name an active cluster
    a_best_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.asn_acc |-> (SB'(r_best) <= w_lim))
        else $error("best cluster beyond active range");
    // dividers are idle whenever a new division starts
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_cmd.div_start) |-> $past(o_sts.div_done))
        else $error("divider restarted while busy");
    // update results come out in cluster order
    a_upd_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_out |=> (o_idx == $past(SB'(r_wi))))
        else $error("update result out of order");
endmodule

### hw/rtl/kmau_ctrl.sv
// ----------------------------------------------------------------------------
// kmau_ctrl: controller for the 2-D k-means unit
// Sequences reset clearing, centroid walk, per-cluster division and output.
// ----------------------------------------------------------------------------
module kmau_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic [kmau_pkg::CMD_BITS-1:0]       i_in_cmd,
    output logic                                o_in_ready,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  kmau_pkg::t_dp_sts                   i_sts,
    output kmau_pkg::t_dp_cmd                   o_cmd
);
    kmau_pkg::t_state r_state, n_state;
    logic             r_ov, n_ov;
    logic             w_take, w_oslot;

    assign w_oslot   = !r_ov || i_out_ready;
    assign o_out_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmau_pkg::ST_CLEAR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_ov       = r_ov && !i_out_ready;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        w_take     = 1'b0;
        unique case (r_state)
            // reset sweep clears centroids and accumulators
            kmau_pkg::ST_CLEAR: begin
                o_cmd.clr_acc  = 1'b1;
                o_cmd.clr_cent = 1'b1;
                if (i_sts.clr_end) begin
                    n_state = kmau_pkg::ST_IDLE;
                end
            end
            kmau_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                w_take        = i_in_valid;
                o_cmd.capture = w_take;
                o_cmd.idx_rst = w_take;
                if (w_take) begin
                    unique case (kmau_pkg::t_cmd'(i_in_cmd))
                        kmau_pkg::CMD_LOAD:   n_state = kmau_pkg::ST_LOAD;
                        kmau_pkg::CMD_ASSIGN: n_state = kmau_pkg::ST_DIST;
                        kmau_pkg::CMD_UPDATE: n_state = kmau_pkg::ST_UPD_START;
                        default:              n_state = kmau_pkg::ST_IDLE;
                    endcase
                end
            end
            // one-cycle centroid write for a load item
            kmau_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = kmau_pkg::ST_IDLE;
            end
            kmau_pkg::ST_DIST: begin
                o_cmd.sq_calc = 1'b1;
                n_state       = kmau_pkg::ST_CMP;
            end
            kmau_pkg::ST_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_sts.walk_end) begin
                    n_state = kmau_pkg::ST_ASN_OUT;
                end else begin
                    n_state = kmau_pkg::ST_DIST;
                end
            end
            kmau_pkg::ST_ASN_OUT: begin
                if (w_oslot) begin
                    o_cmd.asn_acc = 1'b1;
                    n_ov          = 1'b1;
                    n_state       = kmau_pkg::ST_IDLE;
                end
            end
            kmau_pkg::ST_UPD_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = kmau_pkg::ST_UPD_DIV;
            end
            kmau_pkg::ST_UPD_DIV: begin
                if (i_sts.div_done) begin
                    n_state = kmau_pkg::ST_UPD_OUT;
                end
            end
            kmau_pkg::ST_UPD_OUT: begin
                if (w_oslot) begin
                    o_cmd.upd_out = 1'b1;
                    n_ov          = 1'b1;
                    n_state       = i_sts.walk_end ? kmau_pkg::ST_UPD_CLR
                                                   : kmau_pkg::ST_UPD_START;
                end
            end
            // after an update the sweep clears accumulators only
            kmau_pkg::ST_UPD_CLR: begin
                o_cmd.clr_acc = 1'b1;
                if (i_sts.clr_end) begin
                    n_state = kmau_pkg::ST_IDLE;
                end
            end
            default: n_state = kmau_pkg::ST_IDLE;
        endcase
    end

    // input is taken only when idle
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == kmau_pkg::ST_IDLE))
        else $error("ready outside idle");
    // a result is never written over while still pending
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_out_ready) |-> !(o_cmd.asn_acc || o_cmd.upd_out))
        else $error("result overrun");
    // an assign walk ends in its result state
    a_walk_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmau_pkg::ST_CMP && i_sts.walk_end)
        |=> (r_state == kmau_pkg::ST_ASN_OUT))
        else $error("walk did not end in output");
endmodule

### hw/rtl/kmeans_assign_and_update_2d_unit.sv
// ----------------------------------------------------------------------------
// kmeans_assign_and_update_2d_unit: one pass of 2-D k-means, Q0.16
// Load, assign (nearest centroid) and update (new means) on a stream.
//
//  channel   dir  fields
//  s_axis    in   tuser: command[1:0]; tdata: x[15:0] y[31:16] slot[34:32]
//  m_axis    out  tdata: cluster[2:0] x[18:3] y[34:19] changed[35]; tlast
//  cfg       in   i_cfg_wr / i_cfg_data: active_clusters
//
// Load writes one centroid slot; assign walks the active centroids one
// distance at a time (multiply, then compare) through one multiplier pair;
// update runs the bit-serial dividers (SUM = COORD_BITS+COUNT_BITS bits)
// per active cluster, then clears the CLUSTER_SLOTS accumulator rows. After
// reset a clearing pass over CLUSTER_SLOTS rows runs before input is taken.
// A stalled output holds the controller; one item is worked on at a time.
// ----------------------------------------------------------------------------
module kmeans_assign_and_update_2d_unit #(
    parameter int unsigned CLUSTER_SLOTS = kmau_pkg::CLUSTER_SLOTS_DEF,
    parameter int unsigned COORD_BITS    = kmau_pkg::COORD_BITS_DEF,
    parameter int unsigned COUNT_BITS    = kmau_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command
    input  logic [1:0]  s_axis_tuser,
    // coord_x, coord_y, slot_index from bit 0 up
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // cluster_index, centroid_x, centroid_y, changed from bit 0 up
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_wr,
    input  logic [3:0]  i_cfg_data
);
    kmau_pkg::t_dp_cmd w_cmd;
    kmau_pkg::t_dp_sts w_sts;
    logic [kmau_pkg::K_BITS-1:0] r_k;
    logic [2:0]  w_idx;
    logic [15:0] w_cx, w_cy;
    logic        w_chg;

    // active cluster count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= kmau_pkg::K_RESET;
        end else if (i_cfg_wr) begin
            r_k <= i_cfg_data;
        end
    end

    kmau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_in_cmd(s_axis_tuser),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    kmau_datapath #(
        .CLUSTER_SLOTS(CLUSTER_SLOTS), .COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_k(r_k),
        .i_x(s_axis_tdata[15:0]), .i_y(s_axis_tdata[31:16]),
        .i_slot(s_axis_tdata[34:32]), .o_sts(w_sts),
        .o_idx(w_idx), .o_cx(w_cx), .o_cy(w_cy),
        .o_changed(w_chg), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_chg, w_cy, w_cx, w_idx};
endmodule
